/* sv/rfm_pkg.sv */
// Shared constants, codes and types of the reciprocal frequency meter.
`default_nettype none
package rfm_pkg;

  // Datapath widths fixed by the item fields
  localparam int DATA_W  = 32;
  localparam int VEL_W   = 48;
  localparam int PROD_W  = 2 * DATA_W;
  localparam int FRAC_W  = 16;

  // Default width of the capture timer
  localparam int COUNT_WIDTH_DEF = 32;

  // Bits handled per cycle by the serial divider and multiplier
  localparam int DIGIT = 2;
  localparam int STEPS = DATA_W / DIGIT;
  localparam int CNT_W = $clog2(STEPS);

  // Configuration port
  localparam int CFG_IDX_W = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CLOCK_HZ       = 2'd0,
    REG_COUNTER_TOP    = 2'd1,
    REG_VELOCITY_SCALE = 2'd2,
    REG_UNUSED         = 2'd3
  } cfg_reg_t;

  localparam logic [DATA_W-1:0] CLOCK_HZ_RST    = 32'd168000000;
  localparam logic [DATA_W-1:0] COUNTER_TOP_RST = 32'hFFFF_FFFF;
  localparam logic [DATA_W-1:0] SCALE_RST       = 32'd0;
  localparam logic [DATA_W-1:0] SCALE_ONE       = 32'h0001_0000;

  // Event kinds
  typedef enum logic {
    ACT_CAPTURE  = 1'b0,
    ACT_ROLLOVER = 1'b1
  } action_t;

  // Rollover count saturates here
  localparam logic [1:0] ROLL_SAT = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL
  } state_t;

  // Status of a serial arithmetic unit
  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage
`default_nettype wire

/* sv/rfm_if.sv */
// Stream interfaces for timer events in and measurements out.
`default_nettype none
interface rfm_in_if;
  logic                      valid;
  logic                      ready;
  logic                      action;
  logic [rfm_pkg::DATA_W-1:0] capture_value;

  modport source (output valid, output action, output capture_value, input ready);
  modport sink   (input valid, input action, input capture_value, output ready);
endinterface

interface rfm_out_if;
  logic                      valid;
  logic                      ready;
  logic [rfm_pkg::DATA_W-1:0] frequency;
  logic [rfm_pkg::VEL_W-1:0]  velocity;
  logic                      too_slow;

  modport source (output valid, output frequency, output velocity, output too_slow,
                  input ready);
  modport sink   (input valid, input frequency, input velocity, input too_slow,
                  output ready);
endinterface
`default_nettype wire

/* sv/rfm_divider.sv */
// Serial restoring divider, DIGIT quotient bits per cycle; zero divisor gives all ones.
`default_nettype none
module rfm_divider (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rfm_pkg::DATA_W-1:0] dividend,
  input  wire logic [rfm_pkg::DATA_W-1:0] divisor,
  output rfm_pkg::unit_status_t           status,
  output logic      [rfm_pkg::DATA_W-1:0] quotient
);
  import rfm_pkg::*;

  logic [DATA_W-1:0] rem, rem_next;
  logic [DATA_W-1:0] quo, quo_next;
  logic [DATA_W-1:0] den;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic              done;

  // One digit of restoring division
  always_comb begin
    logic [DATA_W:0]   partial;
    logic [DATA_W+1:0] diff;
    rem_next = rem;
    quo_next = quo;
    for (int i = 0; i < DIGIT; i++) begin
      partial = {rem_next, quo_next[DATA_W-1]};
      diff    = {1'b0, partial} - {2'b00, den};
      if (!diff[DATA_W+1]) begin
        rem_next = diff[DATA_W-1:0];
        quo_next = {quo_next[DATA_W-2:0], 1'b1};
      end else begin
        rem_next = partial[DATA_W-1:0];
        quo_next = {quo_next[DATA_W-2:0], 1'b0};
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Operands and partial results
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      den <= divisor;
    end else if (busy) begin
      rem <= rem_next;
      quo <= quo_next;
    end
  end

  assign status   = '{busy: busy, done: done};
  assign quotient = quo;

endmodule
`default_nettype wire

/* sv/rfm_multiplier.sv */
// Serial shift-add multiplier, DIGIT multiplier bits per cycle, full product kept.
`default_nettype none
module rfm_multiplier (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       start,
  input  wire logic [rfm_pkg::DATA_W-1:0] multiplicand,
  input  wire logic [rfm_pkg::DATA_W-1:0] multiplier,
  output rfm_pkg::unit_status_t           status,
  output logic      [rfm_pkg::PROD_W-1:0] product
);
  import rfm_pkg::*;

  logic [DATA_W-1:0] hi, hi_next;
  logic [DATA_W-1:0] lo, lo_next;
  logic [DATA_W-1:0] mcand;
  logic [CNT_W-1:0]  count;
  logic              busy;
  logic              done;

  // One digit: add where the multiplier bit is set, then shift right
  always_comb begin
    logic [DATA_W:0] sum;
    hi_next = hi;
    lo_next = lo;
    for (int i = 0; i < DIGIT; i++) begin
      sum     = {1'b0, hi_next} + (lo_next[0] ? {1'b0, mcand} : '0);
      hi_next = sum[DATA_W:1];
      lo_next = {sum[0], lo_next[DATA_W-1:1]};
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CNT_W'(1);
        if (count == CNT_W'(STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Accumulator; holds the product once finished
  always_ff @(posedge clk) begin
    if (start) begin
      hi    <= '0;
      lo    <= multiplier;
      mcand <= multiplicand;
    end else if (busy) begin
      hi <= hi_next;
      lo <= lo_next;
    end
  end

  assign status  = '{busy: busy, done: done};
  assign product = {hi, lo};

endmodule
`default_nettype wire

/* sv/reciprocal_frequency_meter_unit.sv */
// Top level of the reciprocal frequency meter: event handling, sequencing and output.
// Each timer event yields one measurement. A rising-edge capture works out the period
// since the previous capture (adding counter_top when the count did not increase),
// divides clock_hz by it in a serial divider that takes two quotient bits per cycle,
// then scales the frequency by velocity_scale (zero counting as one) in a serial
// multiplier of the same digit size. A capture runs through the two 16-step serial
// units one after the other before its result is loaded into the output register.
// A timer rollover skips the divider and goes straight to the multiplier. A result
// held off at the output keeps the unit in the multiply phase until the output frees
// up. The next event is taken as soon as the previous measurement sits in the output
// register; configuration must be written only while the unit is idle.
`default_nettype none
module reciprocal_frequency_meter_unit #(
  parameter int COUNT_WIDTH = rfm_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  rfm_in_if.sink                             in_ch,
  rfm_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [rfm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rfm_pkg::DATA_W-1:0]    cfg_data
);
  import rfm_pkg::*;

  // Configuration registers
  logic [DATA_W-1:0] clock_hz;
  logic [DATA_W-1:0] counter_top;
  logic [DATA_W-1:0] velocity_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_hz       <= CLOCK_HZ_RST;
      counter_top    <= COUNTER_TOP_RST;
      velocity_scale <= SCALE_RST;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_CLOCK_HZ:       clock_hz       <= cfg_data;
        REG_COUNTER_TOP:    counter_top    <= cfg_data;
        REG_VELOCITY_SCALE: velocity_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  // Measurement state
  logic [COUNT_WIDTH-1:0] previous_capture;
  logic [DATA_W-1:0]      held_frequency;
  logic [1:0]             rollover_count;

  state_t state, state_next;
  logic   in_xfer;
  logic   div_start;
  logic   mul_start;
  logic   out_load;
  logic   out_free;

  unit_status_t      div_status;
  unit_status_t      mul_status;
  logic [DATA_W-1:0] quotient;
  logic [PROD_W-1:0] product;

  // Period since the previous capture, on the full datapath width
  logic [COUNT_WIDTH-1:0] capture;
  logic [DATA_W-1:0]      cap_ext;
  logic [DATA_W-1:0]      prev_ext;
  logic [DATA_W-1:0]      period;

  assign capture  = in_ch.capture_value[COUNT_WIDTH-1:0];
  assign cap_ext  = DATA_W'(capture);
  assign prev_ext = DATA_W'(previous_capture);
  assign period   = (cap_ext > prev_ext) ? (cap_ext - prev_ext)
                                         : (counter_top + cap_ext - prev_ext);

  assign out_free = !out_ch.valid || out_ch.ready;
  assign in_xfer  = in_ch.valid && in_ch.ready;

  // Sequencer state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencer next state and strobes
  always_comb begin
    state_next  = state;
    in_ch.ready = 1'b0;
    div_start   = 1'b0;
    mul_start   = 1'b0;
    out_load    = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          if (action_t'(in_ch.action) == ACT_CAPTURE) begin
            div_start  = 1'b1;
            state_next = ST_DIV;
          end else begin
            mul_start  = 1'b1;
            state_next = ST_MUL;
          end
        end
      end
      ST_DIV: begin
        if (div_status.done) begin
          mul_start  = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        if (!mul_status.busy && out_free) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Capture and rollover bookkeeping
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_capture <= '0;
      held_frequency   <= '0;
      rollover_count   <= '0;
    end else begin
      if (in_xfer) begin
        if (action_t'(in_ch.action) == ACT_CAPTURE) begin
          previous_capture <= capture;
          rollover_count   <= '0;
        end else begin
          if (rollover_count != ROLL_SAT) begin
            rollover_count <= rollover_count + 2'd1;
          end
          if (rollover_count != 2'd0) begin
            held_frequency <= '0;
          end
        end
      end
      if (state == ST_DIV && div_status.done) begin
        held_frequency <= quotient;
      end
    end
  end

  // Serial arithmetic units
  logic [DATA_W-1:0] scale_eff;
  assign scale_eff = (velocity_scale == '0) ? SCALE_ONE : velocity_scale;

  // Frequency the coming result carries, ahead of the held register
  logic [DATA_W-1:0] freq_next;
  assign freq_next = (state == ST_DIV)        ? quotient :
                     (rollover_count != 2'd0) ? '0       : held_frequency;

  rfm_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (clock_hz),
    .divisor  (period),
    .status   (div_status),
    .quotient (quotient)
  );

  rfm_multiplier u_mul (
    .clk          (clk),
    .rst          (rst),
    .start        (mul_start),
    .multiplicand (freq_next),
    .multiplier   (scale_eff),
    .status       (mul_status),
    .product      (product)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (out_load) begin
      out_ch.valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_ch.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ch.frequency <= held_frequency;
      out_ch.velocity  <= product[FRAC_W +: VEL_W];
      out_ch.too_slow  <= (rollover_count == ROLL_SAT);
    end
  end

`ifndef SYNTHESIS
  // A second rollover without an edge forces the frequency to zero
  a_rollover_zero: assert property (@(posedge clk) disable iff (rst)
    in_xfer && action_t'(in_ch.action) == ACT_ROLLOVER && rollover_count != 2'd0
    |=> held_frequency == '0)
    else $error("frequency not cleared after repeated rollover");

  // A too-slow result always carries zero frequency
  a_slow_freq: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.too_slow |-> out_ch.frequency == '0)
    else $error("too_slow result with nonzero frequency");

  // The divider only runs while the sequencer waits on it
  a_div_owner: assert property (@(posedge clk) disable iff (rst)
    div_status.busy |-> state == ST_DIV)
    else $error("divider busy outside the divide phase");

  // The rollover count never passes saturation
  a_roll_sat: assert property (@(posedge clk) disable iff (rst)
    rollover_count != 2'd3)
    else $error("rollover count beyond saturation");
`endif

endmodule
`default_nettype wire
